// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check an implication on every rising clock edge outside reset
`define CHK_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed");
// Check an implication in the next cycle
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed");
`endif

// ===== rtl/hsha_pkg.sv =====
// Package with SHA-1 constants, types and round helpers
package hsha_pkg;
    localparam int unsigned KeyWords = 8;
    localparam int unsigned KeyIdxW = 3;
    localparam int unsigned CfgW = 64;
    localparam int unsigned QueueDepth = 4;
    localparam int unsigned QueuePtrW = 2;

    localparam logic [31:0] Iv0 = 32'h67452301;
    localparam logic [31:0] Iv1 = 32'hEFCDAB89;
    localparam logic [31:0] Iv2 = 32'h98BADCFE;
    localparam logic [31:0] Iv3 = 32'h10325476;
    localparam logic [31:0] Iv4 = 32'hC3D2E1F0;
    localparam logic [7:0] IPad = 8'h36;
    localparam logic [7:0] OPad = 8'h5c;
    localparam logic [7:0] PadByte = 8'h80;

    // Item as queued between front and back
    typedef struct packed {
        logic [7:0] msg_byte;
        logic       byte_valid;
        logic       end_of_message;
    } t_item;

    // Control from the round engine to the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } t_core_status;

    function automatic logic [31:0] sha_k(input logic [6:0] rnd);
        logic [31:0] k;
        if (rnd < 7'd20) k = 32'h5A827999;
        else if (rnd < 7'd40) k = 32'h6ED9EBA1;
        else if (rnd < 7'd60) k = 32'h8F1BBCDC;
        else k = 32'hCA62C1D6;
        return k;
    endfunction

    function automatic logic [31:0] sha_f(input logic [6:0] rnd, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
        logic [31:0] f;
        if (rnd < 7'd20) f = (b & c) | (~b & d);
        else if (rnd < 7'd40) f = b ^ c ^ d;
        else if (rnd < 7'd60) f = (b & c) | (b & d) | (c & d);
        else f = b ^ c ^ d;
        return f;
    endfunction
endpackage

// ===== rtl/hsha_stream_if.sv =====
// Valid/ready channel interface with a generic payload
interface hsha_stream_if #(parameter int unsigned Width = 8);
    logic             valid;
    logic             ready;
    logic [Width-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/hsha_front.sv =====
// Front part: accept items and hold them in a short queue
module hsha_front import hsha_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_item i_item,
    input  logic  i_pop,
    output logic  o_avail,
    output t_item o_item
);
    t_item r_q [QueueDepth];
    logic [QueuePtrW-1:0] r_wp, r_rp;
    logic [QueuePtrW:0]   r_cnt;
    logic push;

    assign o_ready = (r_cnt != QueuePtrW'(0) + (QueuePtrW+1)'(QueueDepth));
    assign push    = i_valid && o_ready;
    assign o_avail = (r_cnt != '0);
    assign o_item  = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wp] <= i_item;
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wp <= r_wp + 1'b1;
            if (i_pop) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (QueuePtrW+1)'(push) - (QueuePtrW+1)'(i_pop);
        end
    end
endmodule

// ===== rtl/hsha_core.sv =====
// SHA-1 compression: one round per cycle with a 16-word schedule window
module hsha_core import hsha_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [159:0] i_chain,
    input  logic [511:0] i_block,
    output t_core_status o_status,
    output logic [159:0] o_chain
);
    logic [31:0] r_w [16];
    logic [31:0] r_a, r_b, r_c, r_d, r_e;
    logic [159:0] r_h;
    logic [6:0] r_rnd;
    logic r_busy, r_done;
    logic [31:0] wt, wn, t;

    assign wt = r_w[0];
    assign wn = {r_w[13] ^ r_w[8] ^ r_w[2] ^ r_w[0]} << 1
              | {31'd0, (r_w[13][31] ^ r_w[8][31] ^ r_w[2][31] ^ r_w[0][31])};
    assign t  = {r_a[26:0], r_a[31:27]} + sha_f(r_rnd, r_b, r_c, r_d) + r_e
              + sha_k(r_rnd) + wt;
    assign o_status = '{busy: r_busy, done: r_done};
    // fold the working words into the chain; valid from done until the next start
    assign o_chain  = {r_h[159:128] + r_a, r_h[127:96] + r_b, r_h[95:64] + r_c,
                       r_h[63:32] + r_d, r_h[31:0] + r_e};

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            for (int i = 0; i < 16; i++) r_w[i] <= i_block[511-32*i -: 32];
            {r_a, r_b, r_c, r_d, r_e} <= i_chain;
            r_h <= i_chain;
        end else if (r_busy) begin
            for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
            r_w[15] <= wn;
            r_e <= r_d;
            r_d <= r_c;
            r_c <= {r_b[1:0], r_b[31:2]};
            r_b <= r_a;
            r_a <= t;
        end
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_rnd <= '0;
        end else begin
            r_done <= !i_start && r_busy && (r_rnd == 7'd79);
            if (i_start) begin
                r_busy <= 1'b1;
                r_rnd <= '0;
            end else if (r_busy) begin
                r_rnd <= r_rnd + 7'd1;
                if (r_rnd == 7'd79) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end
endmodule

// ===== rtl/hsha_back.sv =====
// Back part: message sequencer, padding, inner and outer hash, digest out
module hsha_back import hsha_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [511:0]  i_key,
    input  logic          i_avail,
    input  t_item         i_item,
    output logic          o_pop,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [31:0]   o_digest_word,
    output logic [2:0]    o_word_index,
    output logic          o_last_word
);
    typedef enum logic [3:0] {
        S_IDLE, S_TAKE, S_IKEY, S_BYTE, S_PAD1, S_PAD2, S_OKEY, S_OMSG, S_WAIT, S_OUT
    } t_state;

    t_state r_state, r_ret;
    logic [511:0] r_buf;
    logic [159:0] r_chain, r_inner;
    logic [63:0]  r_bits;
    logic [5:0]   r_fill;
    logic         r_open, r_last, r_cv, r_full;
    logic [2:0]   r_idx;
    logic [31:0]  r_word;
    logic         start;
    logic [511:0] blk, keyblk_i, keyblk_o, padblk, padfill;
    t_core_status st;
    logic [159:0] cout;
    logic [159:0] iv;

    assign iv = {Iv0, Iv1, Iv2, Iv3, Iv4};
    always_comb begin
        for (int i = 0; i < 64; i++) begin
            keyblk_i[511-8*i -: 8] = i_key[511-8*i -: 8] ^ IPad;
            keyblk_o[511-8*i -: 8] = i_key[511-8*i -: 8] ^ OPad;
        end
        padblk = {r_inner, PadByte, 280'd0, 64'd672};
        // pad marker at the fill position, zeros after it
        padfill = r_buf;
        for (int i = 0; i < 64; i++) begin
            if (i == int'(r_fill)) padfill[511-8*i -: 8] = PadByte;
            else if (i > int'(r_fill)) padfill[511-8*i -: 8] = 8'd0;
        end
    end

    hsha_core u_core (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start),
        .i_chain((r_state == S_IKEY || r_state == S_OKEY) ? iv : r_chain),
        .i_block(blk), .o_status(st), .o_chain(cout)
    );

    always_comb begin
        start = 1'b0;
        blk = r_buf;
        case (r_state)
            S_IKEY: begin start = 1'b1; blk = keyblk_i; end
            S_OKEY: begin start = 1'b1; blk = keyblk_o; end
            S_OMSG: begin start = 1'b1; blk = padblk; end
            S_PAD1, S_PAD2: start = 1'b1;
            default: ;
        endcase
    end

    assign o_pop = (r_state == S_IDLE) && i_avail;
    assign o_valid = r_cv;
    assign o_digest_word = r_word;
    assign o_word_index = r_idx;
    assign o_last_word = (r_idx == 3'd4);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ret <= S_IDLE;
            r_open <= 1'b0;
            r_fill <= '0;
            r_bits <= '0;
            r_cv <= 1'b0;
            r_idx <= '0;
            r_last <= 1'b0;
            r_full <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: if (i_avail) begin
                    r_last <= i_item.end_of_message;
                    r_full <= i_item.byte_valid && (r_fill == 6'd63);
                    if (i_item.byte_valid) begin
                        r_buf[511-8*r_fill -: 8] <= i_item.msg_byte;
                    end
                    if (!r_open) begin
                        r_open <= 1'b1;
                        r_fill <= i_item.byte_valid ? 6'd1 : 6'd0;
                        r_bits <= i_item.byte_valid ? 64'd520 : 64'd512;
                        r_state <= S_IKEY;
                    end else begin
                        if (i_item.byte_valid) r_fill <= r_fill + 6'd1;
                        r_bits <= r_bits + (i_item.byte_valid ? 64'd8 : 64'd0);
                        r_state <= S_TAKE;
                    end
                end
                S_IKEY: begin r_ret <= S_TAKE; r_state <= S_WAIT; end
                S_TAKE: begin
                    // full block wraps fill to zero: compress it
                    if (r_full) begin
                        r_full <= 1'b0;
                        r_ret <= S_BYTE;
                        r_state <= S_PAD1;
                    end else if (r_last) begin
                        r_buf <= padfill;
                        r_ret <= S_PAD2;
                        r_state <= S_BYTE;
                    end else begin
                        r_ret <= S_IDLE;
                        r_state <= S_IDLE;
                    end
                end
                S_PAD1: begin r_state <= S_WAIT; end
                S_BYTE: begin
                    if (r_ret == S_BYTE) begin
                        // block done; continue with padding if last
                        r_ret <= S_IDLE;
                        if (r_last) r_state <= S_TAKE; else r_state <= S_IDLE;
                    end else if (r_fill > 6'd55) begin
                        r_state <= S_PAD2;
                        r_ret <= S_PAD1;
                    end else begin
                        r_buf[63:0] <= r_bits;
                        r_state <= S_PAD2;
                        r_ret <= S_OKEY;
                    end
                end
                S_PAD2: r_state <= S_WAIT;
                S_WAIT: if (st.done) begin
                    r_chain <= cout;
                    case (r_ret)
                        S_PAD1: begin
                            r_buf <= {448'd0, r_bits};
                            r_ret <= S_OKEY;
                            r_state <= S_PAD2;
                        end
                        S_OKEY: begin r_inner <= cout; r_state <= S_OKEY; end
                        S_OMSG: begin r_ret <= S_OUT; r_state <= S_OMSG; end
                        S_OUT: begin
                            r_state <= S_OUT;
                            r_cv <= 1'b1;
                            r_idx <= '0;
                            r_word <= cout[159:128];
                        end
                        default: r_state <= r_ret;
                    endcase
                end
                S_OKEY: begin r_ret <= S_OMSG; r_state <= S_WAIT; end
                S_OMSG: r_state <= S_WAIT;
                S_OUT: if (i_ready) begin
                    if (r_idx == 3'd4) begin
                        r_cv <= 1'b0;
                        r_open <= 1'b0;
                        r_fill <= '0;
                        r_bits <= '0;
                        r_ret <= S_IDLE;
                        r_state <= S_IDLE;
                    end else begin
                        r_idx <= r_idx + 3'd1;
                        r_word <= r_chain[127 - 32*r_idx -: 32];
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== rtl/hmac_sha1_engine.sv =====
// Top level of the HMAC-SHA1 engine
//  channel   dir  payload
//  in_ch     in   msg_byte, byte_valid, end_of_message
//  out_ch    out  digest_word, word_index, last_word
//  cfg       in   key_word_0..7 via i_cfg_we / i_cfg_idx / i_cfg_data
// Each data byte passes the states S_IDLE and S_TAKE; every 64th byte adds one
// compression in the single-round SHA-1 unit. The first item of a message adds
// one key-block compression, the final item three or four more plus five output
// words. Reset is synchronous; the queue of four items lets input flow while the
// back part compresses or the output stalls.
module hmac_sha1_engine import hsha_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [KeyIdxW-1:0]  i_cfg_idx,
    input  logic [CfgW-1:0]     i_cfg_data,
    hsha_stream_if.sink         in_ch,
    hsha_stream_if.source       out_ch
);
    logic [CfgW-1:0] r_key [KeyWords];
    logic [511:0] key;
    logic avail, pop;
    t_item qitem;
    logic [31:0] dw;
    logic [2:0] wi;
    logic lw;

    // hold the key registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < KeyWords; i++) r_key[i] <= '0;
        end else if (i_cfg_we) begin
            r_key[i_cfg_idx] <= i_cfg_data;
        end
    end
    always_comb for (int i = 0; i < KeyWords; i++) key[511-64*i -: 64] = r_key[i];

    hsha_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(in_ch.valid), .o_ready(in_ch.ready),
        .i_item(t_item'(in_ch.data)), .i_pop(pop), .o_avail(avail), .o_item(qitem)
    );

    hsha_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_key(key), .i_avail(avail), .i_item(qitem),
        .o_pop(pop), .o_valid(out_ch.valid), .i_ready(out_ch.ready),
        .o_digest_word(dw), .o_word_index(wi), .o_last_word(lw)
    );
    assign out_ch.data = {dw, wi, lw};
endmodule

// ===== rtl/hsha_checker.sv =====
// Port-level checker for the HMAC-SHA1 engine and its bind
`include "assert_macros.svh"
module hsha_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_ready,
    input logic [35:0] o_data
);
    `CHK_IMPLY(a_idx_range, i_clk, i_rst_n, o_valid, o_data[3:1] <= 3'd4)
    `CHK_IMPLY(a_last_flag, i_clk, i_rst_n, o_valid, o_data[0] == (o_data[3:1] == 3'd4))
    `CHK_NEXT(a_idx_step, i_clk, i_rst_n, o_valid && i_ready && !o_data[0],
              o_valid && o_data[3:1] == $past(o_data[3:1]) + 3'd1)
    `CHK_NEXT(a_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_data))
endmodule

bind hmac_sha1_engine hsha_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_valid(out_ch.valid),
    .i_ready(out_ch.ready), .o_data(out_ch.data)
);

// ===== tb/tb_hmac_sha1_engine.sv =====
// Self-checking testbench for the HMAC-SHA1 engine with a built-in digest predictor
`timescale 1ns / 1ps

import hsha_pkg::*;

// Predicts the digest words from the accepted bytes and checks each returned word
class hmac_digest_board;
    bit [63:0]  key_reg[KeyWords];
    bit [31:0]  inner_hv[5];
    bit [63:0]  bit_total;
    bit [7:0]   byte_buf[64];
    int unsigned fill;
    bit         msg_open;
    bit [35:0]  digest_q[$];
    int unsigned mismatches;
    int unsigned words_ok;
    int unsigned digests_done;

    function new();
        foreach (key_reg[i]) key_reg[i] = '0;
        mismatches = 0;
        words_ok = 0;
        digests_done = 0;
        clear_msg();
    endfunction

    function void clear_msg();
        inner_hv[0] = Iv0; inner_hv[1] = Iv1; inner_hv[2] = Iv2;
        inner_hv[3] = Iv3; inner_hv[4] = Iv4;
        bit_total = '0;
        fill = 0;
        msg_open = 1'b0;
    endfunction

    function void set_key(int unsigned idx, bit [63:0] value);
        key_reg[idx] = value;
    endfunction

    function void load_key_block(output bit [7:0] blk[64], input bit [7:0] pad);
        for (int i = 0; i < 64; i++) begin
            blk[i] = key_reg[i / 8][63 - 8 * (i % 8) -: 8] ^ pad;
        end
    endfunction

    // Run 80 SHA-1 rounds over one block and fold the result into hv
    function void sha1_block(inout bit [31:0] hv[5], input bit [7:0] blk[64]);
        bit [31:0] w[80];
        bit [31:0] a, b, c, d, e, f, k, t, x;
        for (int i = 0; i < 16; i++) begin
            w[i] = {blk[4 * i], blk[4 * i + 1], blk[4 * i + 2], blk[4 * i + 3]};
        end
        for (int i = 16; i < 80; i++) begin
            x = w[i - 3] ^ w[i - 8] ^ w[i - 14] ^ w[i - 16];
            w[i] = {x[30:0], x[31]};
        end
        a = hv[0]; b = hv[1]; c = hv[2]; d = hv[3]; e = hv[4];
        for (int i = 0; i < 80; i++) begin
            if (i < 20) begin
                f = (b & c) | (~b & d); k = 32'h5A827999;
            end else if (i < 40) begin
                f = b ^ c ^ d; k = 32'h6ED9EBA1;
            end else if (i < 60) begin
                f = (b & c) | (b & d) | (c & d); k = 32'h8F1BBCDC;
            end else begin
                f = b ^ c ^ d; k = 32'hCA62C1D6;
            end
            t = {a[26:0], a[31:27]} + f + e + k + w[i];
            e = d; d = c; c = {b[1:0], b[31:2]}; b = a; a = t;
        end
        hv[0] += a; hv[1] += b; hv[2] += c; hv[3] += d; hv[4] += e;
    endfunction

    // Advance the prediction by one accepted item
    function void note_item(t_item it);
        bit [7:0]  blk[64];
        bit [31:0] outer_hv[5];
        int unsigned pos;
        if (!msg_open) begin
            clear_msg();
            load_key_block(blk, IPad);
            sha1_block(inner_hv, blk);
            bit_total = 64'd512;
            msg_open = 1'b1;
        end
        if (it.byte_valid) begin
            byte_buf[fill] = it.msg_byte;
            fill++;
            bit_total += 64'd8;
            if (fill == 64) begin
                sha1_block(inner_hv, byte_buf);
                fill = 0;
            end
        end
        if (!it.end_of_message) return;
        // inner padding, spilling into a second block when the length does not fit
        pos = fill;
        byte_buf[pos++] = PadByte;
        if (pos > 56) begin
            while (pos < 64) byte_buf[pos++] = 8'h00;
            sha1_block(inner_hv, byte_buf);
            pos = 0;
        end
        while (pos < 56) byte_buf[pos++] = 8'h00;
        for (int i = 0; i < 8; i++) byte_buf[56 + i] = bit_total[63 - 8 * i -: 8];
        sha1_block(inner_hv, byte_buf);
        // outer hash over the opad key block and the inner digest
        outer_hv[0] = Iv0; outer_hv[1] = Iv1; outer_hv[2] = Iv2;
        outer_hv[3] = Iv3; outer_hv[4] = Iv4;
        load_key_block(blk, OPad);
        sha1_block(outer_hv, blk);
        foreach (blk[i]) blk[i] = 8'h00;
        for (int i = 0; i < 5; i++) begin
            {blk[4 * i], blk[4 * i + 1], blk[4 * i + 2], blk[4 * i + 3]} = inner_hv[i];
        end
        blk[20] = PadByte;
        {blk[56], blk[57], blk[58], blk[59], blk[60], blk[61], blk[62], blk[63]} = 64'd672;
        sha1_block(outer_hv, blk);
        for (int i = 0; i < 5; i++) begin
            digest_q.push_back({outer_hv[i], 3'(i), i == 4});
        end
        clear_msg();
    endfunction

    // Compare one returned word against the oldest expected word
    function void check_word(bit [35:0] got);
        bit [35:0] want;
        if (digest_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("ERROR: unexpected digest word %h", got);
            return;
        end
        want = digest_q.pop_front();
        if (got[35:4] !== want[35:4] || got[3:1] !== want[3:1] || got[0] !== want[0]) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("ERROR: digest word mismatch: expected word %h index %0d last %0b, got word %h index %0d last %0b",
                         want[35:4], want[3:1], want[0], got[35:4], got[3:1], got[0]);
            end
        end else begin
            words_ok++;
            if (want[0]) digests_done++;
        end
    endfunction

    function int unsigned pending();
        return digest_q.size();
    endfunction
endclass

module tb_hmac_sha1_engine;
    localparam int unsigned CycleLimit = 600000;
    localparam int unsigned DrainCycles = 400;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [KeyIdxW-1:0] i_cfg_idx;
    logic [CfgW-1:0] i_cfg_data;

    hsha_stream_if #(.Width($bits(t_item))) in_ch ();
    hsha_stream_if #(.Width(36)) out_ch ();

    hmac_sha1_engine i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .in_ch      (in_ch.sink),
        .out_ch     (out_ch.source)
    );

    hmac_digest_board board;
    int unsigned send_gap_pct;
    int unsigned recv_stall_pct;
    int unsigned data_items;
    int unsigned msg_count;
    int unsigned cycle_cnt;

    // 20 ns clock
    always begin
        i_clk = 1'b1; #10;
        i_clk = 1'b0; #10;
    end

    // Abort on a hang
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CycleLimit) begin
            $display("ERROR: timeout after %0d cycles", cycle_cnt);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Stall the digest port at random, changing on the falling edge
    always @(negedge i_clk) begin
        out_ch.ready = ($urandom_range(99) >= recv_stall_pct);
    end

    // Check every accepted digest word on the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) board.check_word(out_ch.data);
    end

    // Write one key register; called on a falling edge, returns on the next one
    task automatic write_key(int unsigned idx, logic [63:0] value);
        i_cfg_we = 1'b1;
        i_cfg_idx = KeyIdxW'(idx);
        i_cfg_data = value;
        board.set_key(idx, value);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // Hold valid until the item is taken; random gaps go in front
    task automatic send_item(logic [7:0] b, logic bv, logic eom);
        t_item it;
        it.msg_byte = b;
        it.byte_valid = bv;
        it.end_of_message = eom;
        while ($urandom_range(99) < send_gap_pct) begin
            in_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid = 1'b1;
        in_ch.data = it;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        board.note_item(it);
        if (bv) data_items++;
        @(negedge i_clk);
        in_ch.valid = 1'b0;
    endtask

    // Stream one message; sprinkle empty items and pick how it closes
    task automatic send_message(int unsigned len);
        logic [7:0] b;
        bit close_empty;
        close_empty = (len == 0) || ($urandom_range(3) == 0);
        for (int unsigned n = 0; n < len; n++) begin
            if ($urandom_range(19) == 0) send_item(8'($urandom_range(255)), 1'b0, 1'b0);
            b = 8'($urandom_range(255));
            send_item(b, 1'b1, (n == len - 1) && !close_empty);
        end
        if (close_empty) send_item(8'($urandom_range(255)), 1'b0, 1'b1);
        msg_count++;
    endtask

    // Wait out outstanding digests and any compression still in flight
    task automatic wait_idle();
        while (board.pending() != 0) @(negedge i_clk);
        repeat (DrainCycles) @(negedge i_clk);
    endtask

    function automatic int unsigned pick_len();
        case ($urandom_range(11))
            0: return 0;
            1: return 55;
            2: return 56;
            3: return 63;
            4: return 64;
            5: return 65;
            6: return 119 + $urandom_range(2);
            default: return $urandom_range(1, 20);
        endcase
    endfunction

    initial begin
        int unsigned phase_target;
        board = new();
        cycle_cnt = 0;
        data_items = 0;
        msg_count = 0;
        send_gap_pct = 0;
        recv_stall_pct = 0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b1;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed: reset key, empty message, open-without-data, single extreme bytes
        send_item(8'h00, 1'b0, 1'b1);
        send_item(8'hA5, 1'b0, 1'b0);
        send_item(8'h5A, 1'b0, 1'b1);
        send_item(8'hFF, 1'b1, 1'b1);
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'hFF, 1'b1, 1'b0);
        send_item(8'h00, 1'b0, 1'b1);
        send_message(3);
        wait_idle();

        for (int phase = 0; phase < 4; phase++) begin
            // Key extremes first, then random and short zero-padded keys
            for (int unsigned i = 0; i < KeyWords; i++) begin
                case (phase)
                    0: write_key(i, 64'h0);
                    1: write_key(i, '1);
                    2: write_key(i, {$urandom, $urandom});
                    default: write_key(i, (i < 3) ? {$urandom, $urandom} : 64'h0);
                endcase
            end
            case (phase)
                0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_gap_pct = 65; recv_stall_pct = 0;  end
                2: begin send_gap_pct = 0;  recv_stall_pct = 65; end
                default: begin send_gap_pct = 7; recv_stall_pct = 7; end
            endcase
            phase_target = data_items + 60;
            while (data_items < phase_target) begin
                send_message(pick_len());
                // In phase 1, let the pipe run dry after every fifth message with the sender holding off
                if (phase == 1 && msg_count % 5 == 0) begin
                    while (board.pending() != 0) @(negedge i_clk);
                end
            end
            wait_idle();
        end

        $display("Covered %0d messages, %0d data bytes, %0d digests over four key settings",
                 msg_count, data_items, board.digests_done);
        $display("Mismatches: %0d, words matched: %0d", board.mismatches, board.words_ok);
        if (board.mismatches == 0 && board.pending() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
